[design/firmware_image_header_builder_top_assert.svh]
// Assertion macros for the firmware image header builder.
`ifndef FIRMWARE_IMAGE_HEADER_BUILDER_TOP_ASSERT_SVH
`define FIRMWARE_IMAGE_HEADER_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define FIHB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define FIHB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fihb_pkg.sv]
// Shared types, constants and the byte CRC function of the header builder.
package fihb_pkg;

   localparam int DEF_MAX_IMAGE_BYTES = 131072;
   localparam int CNT_W = 18;
   localparam int CSR_IDX_W = 1;
   localparam int HDR_CNT_W = 6;

   localparam logic [31:0] HDR_MAGIC   = 32'h474F_5441;
   localparam logic [31:0] HDR_SIZE    = 32'd64;
   localparam logic [31:0] REGION_SIZE = 32'h0002_0000;
   localparam logic [31:0] RAM_LOW     = 32'h2000_0000;
   localparam logic [31:0] RAM_HIGH    = 32'h2003_0000;
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] VERSION_RST = 32'd1;
   localparam logic [31:0] LOAD_RST    = 32'h0801_1000;

   localparam logic [CSR_IDX_W-1:0] CSR_VERSION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD    = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE = 3'd1;
   localparam logic [2:0] ST_TOO_SHORT = 3'd2;
   localparam logic [2:0] ST_BAD_STACK = 3'd3;
   localparam logic [2:0] ST_BAD_ENTRY = 3'd4;

   localparam logic [3:0] WORD_HCRC = 4'd7;
   localparam logic [3:0] WORD_LAST = 4'd15;
   localparam logic [HDR_CNT_W-1:0] HDR_BYTE_LAST = 6'd63;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic [3:0]  word_index;
      logic [2:0]  status;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                 take_byte;
      logic                 hcrc_init;
      logic                 hcrc_step;
      logic [HDR_CNT_W-1:0] hcrc_sel;
      logic                 emit_err;
      logic                 emit_word;
      logic [3:0]           word_sel;
      logic                 clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] check_code;
   } dp_stat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[design/fihb_ctrl.sv]
// Sequencer: byte intake, image check, header CRC pass and header word output.
module fihb_ctrl
   import fihb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         last_byte,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd,
   output logic         busy
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_HCRC  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [HDR_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.hcrc_sel = cnt_ff;
      cmd.word_sel = cnt_ff[3:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.take_byte = 1'b1;
               if (last_byte) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (stat.check_code != ST_OK) begin
               cmd.emit_err = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.hcrc_init = 1'b1;
               state_in      = S_HCRC;
            end
         end
         S_HCRC: begin
            cmd.hcrc_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == HDR_BYTE_LAST) begin
               cnt_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit_word = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == WORD_LAST) begin
               cmd.clear = 1'b1;
               cnt_in    = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[design/fihb_dp.sv]
// Datapath: image CRC, byte count, vector words, checks, header CRC and result register.
module fihb_dp
   import fihb_pkg::*;
#(
   parameter int MAX_IMAGE_BYTES = DEF_MAX_IMAGE_BYTES
)(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   input  ctrl_cmd_type         cmd,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IMAGE_BYTES);
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_IMAGE_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(8);
   localparam logic [CNT_W-1:0] CNT_STACK_END = CNT_W'(4);

   logic [31:0]      version_ff, load_ff;
   logic [31:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      stack_ff, stack_in;
   logic [31:0]      entry_ff, entry_in;
   logic [31:0]      hcrc_ff, hcrc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [31:0] region_end, ent;
   logic [31:0] hword, eword;
   logic [7:0]  hbyte;

   function automatic logic [31:0] hdr_word(
      input logic [3:0]       idx,
      input logic [31:0]      w7,
      input logic [CNT_W-1:0] cnt,
      input logic [31:0]      load,
      input logic [31:0]      ver,
      input logic [31:0]      icrc,
      input logic [31:0]      sp,
      input logic [31:0]      ep
   );
      logic [31:0] w;
      case (idx)
         4'd0:    w = HDR_MAGIC;
         4'd1:    w = HDR_SIZE;
         4'd2:    w = {{(32-CNT_W){1'b0}}, cnt};
         4'd3:    w = load;
         4'd4:    w = ver;
         4'd5:    w = icrc ^ CRC_ONES;
         4'd7:    w = w7;
         4'd8:    w = sp;
         4'd9:    w = ep;
         default: w = '0;
      endcase
      return w;
   endfunction

   // image checks, in priority order
   always_comb begin
      region_end = load_ff + REGION_SIZE;
      ent        = {entry_ff[31:1], 1'b0};
      if (count_ff > CNT_MAX) begin
         stat.check_code = ST_TOO_LARGE;
      end else if (count_ff < CNT_MIN) begin
         stat.check_code = ST_TOO_SHORT;
      end else if (stack_ff < RAM_LOW || stack_ff >= RAM_HIGH) begin
         stat.check_code = ST_BAD_STACK;
      end else if (!entry_ff[0] || ent < load_ff || ent >= region_end) begin
         stat.check_code = ST_BAD_ENTRY;
      end else begin
         stat.check_code = ST_OK;
      end
   end

   always_comb begin
      hword = hdr_word(cmd.hcrc_sel[5:2], 32'd0, count_ff, load_ff, version_ff,
                       crc_ff, stack_ff, entry_ff);
      hbyte = 8'(hword >> {cmd.hcrc_sel[1:0], 3'b000});
      eword = hdr_word(cmd.word_sel, hcrc_ff ^ CRC_ONES, count_ff, load_ff, version_ff,
                       crc_ff, stack_ff, entry_ff);
   end

   always_comb begin
      crc_in       = crc_ff;
      count_in     = count_ff;
      stack_in     = stack_ff;
      entry_in     = entry_ff;
      hcrc_in      = hcrc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (cmd.take_byte) begin
         if (count_ff < CNT_STACK_END) begin
            stack_in[{count_ff[1:0], 3'b000} +: 8] = req_data.data_byte;
         end else if (count_ff < CNT_MIN) begin
            entry_in[{count_ff[1:0], 3'b000} +: 8] = req_data.data_byte;
         end
         crc_in = crc_byte(crc_ff, req_data.data_byte);
         if (count_ff < CNT_SAT) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.hcrc_init) begin
         hcrc_in = CRC_ONES;
      end else if (cmd.hcrc_step) begin
         hcrc_in = crc_byte(hcrc_ff, hbyte);
      end
      if (cmd.emit_err) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.header_word = '0;
         rsp_data_in.word_index  = '0;
         rsp_data_in.status      = stat.check_code;
         rsp_data_in.last_of_run = 1'b1;
      end else if (cmd.emit_word) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.header_word = eword;
         rsp_data_in.word_index  = cmd.word_sel;
         rsp_data_in.status      = ST_OK;
         rsp_data_in.last_of_run = (cmd.word_sel == WORD_LAST);
      end
      if (cmd.clear) begin
         crc_in   = CRC_ONES;
         count_in = '0;
         stack_in = '0;
         entry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= VERSION_RST;
         load_ff      <= LOAD_RST;
         crc_ff       <= CRC_ONES;
         count_ff     <= '0;
         stack_ff     <= '0;
         entry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_VERSION) begin
            version_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_LOAD) begin
            load_ff <= csr_wdata;
         end
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         stack_ff     <= stack_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hcrc_ff     <= hcrc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/firmware_image_header_builder_top.sv]
// Top level of the firmware image header builder.
//
//   channel  ports                          direction  handshake
//   request  start, busy, req_data          in         taken when start & !busy
//   result   rsp_valid, rsp_data            out        valid only, no back-pressure
//   config   csr_we, csr_index, csr_wdata   in         taken when csr_we
//
// Image bytes are taken one per cycle while busy is low.
// After a last byte the image is checked; on error one status item follows.
// Otherwise the header CRC unit steps through the 64 header bytes in order,
// then the 16 header words go out in index order without gaps; busy is low again
// in the cycle that shows word 15.
// Synchronous active-high reset restores the state, configuration and rsp_valid registers
// and clears image state. The receiver takes every item in the cycle it is shown.
`include "firmware_image_header_builder_top_assert.svh"

module firmware_image_header_builder_top
   import fihb_pkg::*;
#(
   parameter int MAX_IMAGE_BYTES = DEF_MAX_IMAGE_BYTES
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   fihb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_byte (req_data.last_byte),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   fihb_dp #(
      .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `FIHB_ASSERT_NOW(a_err_is_last, rsp_valid && rsp_data.status != ST_OK, rsp_data.last_of_run, "error item not last")
   `FIHB_ASSERT_NEXT(a_words_back_to_back, rsp_valid && !rsp_data.last_of_run, rsp_valid, "header words not contiguous")
   `FIHB_ASSERT_NEXT(a_index_steps, rsp_valid && !rsp_data.last_of_run, rsp_data.word_index == 4'($past(rsp_data.word_index) + 4'd1), "word index skipped")
   `FIHB_ASSERT_NEXT(a_last_goes_busy, start && !busy && req_data.last_byte, busy, "no busy after last byte")

endmodule
